// ===== sv/hvq_pkg.sv =====
// Package for the hysteresis value quantizer: mode and register codes,
// field widths and the fixed scale factors of the hysteresis thresholds.
// No dependencies.
`timescale 1ns / 1ps

package hvq_pkg;

    // Mode codes of the target_kind register.
    localparam logic [1:0] KIND_CONT = 2'd0;
    localparam logic [1:0] KIND_BOOL = 2'd1;
    localparam logic [1:0] KIND_DISC = 2'd2;

    // Register indexes on the configuration port (word addresses).
    localparam logic [1:0] REG_KIND = 2'd0;
    localparam logic [1:0] REG_MIN  = 2'd1;
    localparam logic [1:0] REG_MAX  = 2'd2;

    // Field and internal widths.
    localparam int INT_W  = 11;   // range limits and held integer
    localparam int D_W    = 11;   // positive range span
    localparam int L_W    = 22;   // span scaled to thousandths of a half step
    localparam int ML_W   = 14;   // hysteresis margin
    localparam int ADDR_W = 4;

    // Scale factors of the threshold arithmetic (boolean thresholds in hundredths, the rest in thousandths).
    localparam int BOUND_SCALE = 1000;
    localparam int SPAN_SCALE  = 2000;
    localparam int BOOL_SCALE  = 100;
    localparam int BOOL_ON     = 55;
    localparam int BOOL_OFF    = 45;
    localparam int MARGIN_LOW  = 100;
    localparam int MARGIN_MID  = 500;
    localparam int MARGIN_HIGH = 4;
    localparam int SPAN_SMALL  = 5;
    localparam int SPAN_MID    = 125;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== sv/hvq_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module hvq_mul #(
    parameter int AW = 17,
    parameter int BW = 22
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    logic [AW+BW-1:0] p_reg;

    // One product per enabled cycle; the result is held otherwise.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= (AW+BW)'(a) * (AW+BW)'(b);
        end
    end

    assign p = p_reg;

endmodule

// ===== sv/hvq_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on hvq_pkg for the span width and the status struct.
`timescale 1ns / 1ps

module hvq_div #(
    parameter int QW = 17
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [hvq_pkg::D_W-1:0] num_hi,
    input  logic [QW-1:0]         num_lo,
    input  logic [hvq_pkg::D_W:0] den,
    output logic [QW-1:0]         quot,
    output hvq_pkg::div_status_t  status
);

    import hvq_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic [D_W:0]   rem_reg;
    logic [D_W:0]   rem_next;
    logic [QW-1:0]  sh_reg;
    logic [QW-1:0]  sh_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic           done_reg;
    logic           done_next;
    logic [D_W+1:0] trial;
    logic           fits;

    // Shift in the next dividend bit and try the subtraction.
    assign trial = {rem_reg, sh_reg[QW-1]};
    assign fits  = trial >= {1'b0, den};

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            // The upper dividend part is below the divisor, so it seeds the remainder.
            rem_next = {1'b0, num_hi};
            sh_next  = num_lo;
            cnt_next = CW'(QW);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? (D_W+1)'(trial - {1'b0, den}) : trial[D_W:0];
            sh_next   = {sh_reg[QW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    // Step counter and completion flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Remainder and dividend/quotient shift register.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign quot        = sh_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

// ===== sv/hysteresis_value_quantizer_unit.sv =====
// Top level of the hysteresis value quantizer: configuration registers,
// sequencer, shared multiplier and divider. Depends on hvq_pkg, hvq_mul and hvq_div.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                       Payload
//  sample    in         sample_valid / sample_ready     sample_level
//  result    out        result_valid / result_ready     stable_level, held_integer
//  config    in         APB psel / penable / pready     paddr, pwdata, prdata
//
//  A discrete item whose held value lies strictly inside the range passes through EVAL,
//  STEP, CMP, RNM, DIV and FIN, its time set by the one-bit-per-cycle divider. A held
//  value at or beyond a range end skips the divider and goes from RNM straight to FIN.
//  Continuous, boolean and empty-range items go from EVAL straight to FIN. Reset clears
//  the held state and loads target_kind 0, range_min 0, range_max 1. A stalled result
//  holds FIN.

module hysteresis_value_quantizer_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Sample channel
    input  logic                         sample_valid,
    output logic                         sample_ready,
    input  logic signed [FRAC_BITS+1:0]  sample_level,
    // Result channel
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [FRAC_BITS:0]           stable_level,
    output logic signed [hvq_pkg::INT_W-1:0] held_integer,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hvq_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    import hvq_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int LW = F + 1;        // level width, 0..1.0
    localparam int PW = LW + L_W;     // multiplier product width
    localparam int VW = F + 13;       // scaled target value width
    localparam int XW = F + 8;        // boolean compare width

    localparam logic [LW-1:0]        ONE_LVL  = LW'(1) << F;
    localparam logic [LW-1:0]        HALF_LVL = LW'(1) << (F - 1);
    localparam logic signed [VW-1:0] HALF_V   = VW'(1) << (F - 1);
    localparam logic [XW-1:0]        ON_THR   = XW'(BOOL_ON) << F;
    localparam logic [XW-1:0]        OFF_THR  = XW'(BOOL_OFF) << F;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_STEP,
        ST_CMP,
        ST_RNM,
        ST_DIV,
        ST_FIN
    } state_t;

    // Configuration registers.
    logic [1:0]              kind_reg;
    logic signed [INT_W-1:0] rmin_reg;
    logic signed [INT_W-1:0] rmax_reg;
    logic                    cfg_wr;

    // Sequencer and held state.
    state_t                  state_reg;
    state_t                  state_next;
    logic signed [INT_W-1:0] held_reg;
    logic signed [INT_W-1:0] held_next;
    logic                    flag_reg;
    logic                    flag_next;
    logic                    primed_reg;
    logic                    primed_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [LW-1:0]           out_level_reg;
    logic [LW-1:0]           out_level_next;
    logic signed [INT_W-1:0] out_int_reg;
    logic signed [INT_W-1:0] out_int_next;

    // Per-item working registers.
    logic [LW-1:0]           x_reg;
    logic [LW-1:0]           x_next;
    logic [D_W-1:0]          d_reg;
    logic [D_W-1:0]          d_next;
    logic [L_W-1:0]          l_reg;
    logic [L_W-1:0]          l_next;
    logic signed [INT_W-1:0] cand_reg;
    logic signed [INT_W-1:0] cand_next;
    logic [L_W:0]            thr_up_reg;
    logic [L_W:0]            thr_up_next;
    logic signed [L_W+1:0]   thr_dn_reg;
    logic signed [L_W+1:0]   thr_dn_next;
    logic [LW-1:0]           lvl_reg;
    logic [LW-1:0]           lvl_next;
    logic signed [INT_W-1:0] int_reg;
    logic signed [INT_W-1:0] int_next;

    // Datapath signals.
    logic [LW-1:0]           x_clamped;
    logic signed [INT_W:0]   d_cfg;
    logic                    d_pos;
    logic [XW-1:0]           x100;
    logic                    act_prev;
    logic                    act;
    logic                    mul_en;
    logic [L_W-1:0]          mul_b;
    logic [PW-1:0]           mul_p;
    logic signed [VW-1:0]    v;
    logic signed [VW-1:0]    v_up;
    logic signed [VW-1:0]    v_mag;
    logic signed [VW-1:0]    cand_neg;
    logic signed [INT_W-1:0] cand_val;
    logic signed [INT_W:0]   n_held;
    logic signed [24:0]      up_raw;
    logic signed [24:0]      dn_raw;
    logic signed [24:0]      l_ext;
    logic [L_W-1:0]          bl_up;
    logic [L_W-1:0]          bl_dn;
    logic [ML_W-1:0]         ml;
    logic                    go_up;
    logic                    go_dn;
    logic                    n_le0;
    logic                    n_ge_d;
    logic                    div_start;
    logic [LW-1:0]           div_quot;
    div_status_t             div_stat;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_CONT;
            rmin_reg <= '0;
            rmax_reg <= INT_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_KIND: kind_reg <= pwdata[1:0];
                REG_MIN:  rmin_reg <= pwdata[INT_W-1:0];
                REG_MAX:  rmax_reg <= pwdata[INT_W-1:0];
                default:  ;
            endcase
        end
    end

    // Register read-back, limits sign-extended.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_KIND: prdata = {30'd0, kind_reg};
            REG_MIN:  prdata = 32'(rmin_reg);
            REG_MAX:  prdata = 32'(rmax_reg);
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input clamp and boolean Schmitt trigger
    // ------------------------------------------------------------------
    always_comb
    begin
        if (sample_level[F+1])
        begin
            x_clamped = '0;
        end
        else if (sample_level[F:0] > ONE_LVL)
        begin
            x_clamped = ONE_LVL;
        end
        else
        begin
            x_clamped = sample_level[F:0];
        end
    end

    assign x100     = XW'(x_reg) * XW'(BOOL_SCALE);
    assign act_prev = primed_reg ? flag_reg : (x_reg >= HALF_LVL);
    assign act      = act_prev ? (x100 > OFF_THR) : (x100 >= ON_THR);

    // Range span taken from the live registers; the user must not change them mid-item (not enforced here).
    assign d_cfg = (INT_W+1)'(rmax_reg) - (INT_W+1)'(rmin_reg);
    assign d_pos = !d_cfg[INT_W] && (d_cfg != '0);

    // ------------------------------------------------------------------
    // Shared multiplier: x * span first, then x * scaled span
    // ------------------------------------------------------------------
    assign mul_en = (state_reg == ST_EVAL) || (state_reg == ST_STEP);
    assign mul_b  = (state_reg == ST_EVAL) ? L_W'(d_cfg[D_W-1:0]) : l_reg;

    hvq_mul #(
        .AW (LW),
        .BW (L_W)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (x_reg),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Candidate integer: lo + x * span, rounded half away from zero.
    assign v        = ((VW)'(rmin_reg) <<< F) + $signed({1'b0, mul_p[F+11:0]});
    assign v_up     = (v + HALF_V) >>> F;
    assign v_mag    = (HALF_V - v) >>> F;
    assign cand_neg = -v_mag;
    assign cand_val = v[VW-1] ? cand_neg[INT_W-1:0] : v_up[INT_W-1:0];

    // Half-step boundaries around the held value, in thousandths of a half step.
    assign n_held = (INT_W+1)'(held_reg) - (INT_W+1)'(rmin_reg);
    assign up_raw = 25'((25'(n_held) * 2 + 1) * BOUND_SCALE);
    assign dn_raw = 25'((25'(n_held) * 2 - 1) * BOUND_SCALE);
    assign l_ext  = $signed({3'b000, l_reg});

    always_comb
    begin
        if (up_raw < 0)
        begin
            bl_up = '0;
        end
        else if (up_raw > l_ext)
        begin
            bl_up = l_reg;
        end
        else
        begin
            bl_up = up_raw[L_W-1:0];
        end
        if (dn_raw < 0)
        begin
            bl_dn = '0;
        end
        else if (dn_raw > l_ext)
        begin
            bl_dn = l_reg;
        end
        else
        begin
            bl_dn = dn_raw[L_W-1:0];
        end
    end

    // Margin: a quarter step held between 0.002 and 0.05.
    always_comb
    begin
        if (d_reg < D_W'(SPAN_SMALL))
        begin
            ml = ML_W'(d_reg * MARGIN_LOW);
        end
        else if (d_reg <= D_W'(SPAN_MID))
        begin
            ml = ML_W'(MARGIN_MID);
        end
        else
        begin
            ml = ML_W'(d_reg * MARGIN_HIGH);
        end
    end

    // Crossing tests against x * scaled span.
    assign go_up = mul_p > {thr_up_reg, {F{1'b0}}};
    assign go_dn = !thr_dn_reg[L_W+1] && (mul_p < {thr_dn_reg[L_W:0], {F{1'b0}}});

    // Renormalizing decisions on the held value.
    assign n_le0  = n_held[INT_W] || (n_held == '0);
    assign n_ge_d = n_held >= $signed({2'b00, d_reg});

    // ------------------------------------------------------------------
    // Shared divider: (2 n ONE + d) / (2 d)
    // ------------------------------------------------------------------
    assign div_start = (state_reg == ST_RNM) && !n_le0 && !n_ge_d;

    hvq_div #(
        .QW (LW)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_hi (n_held[D_W-1:0]),
        .num_lo (LW'(d_reg)),
        .den    ({d_reg, 1'b0}),
        .quot   (div_quot),
        .status (div_stat)
    );

    // ------------------------------------------------------------------
    // Sequencer next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        flag_next      = flag_reg;
        primed_next    = primed_reg;
        out_valid_next = out_valid_reg;
        out_level_next = out_level_reg;
        out_int_next   = out_int_reg;
        x_next         = x_reg;
        d_next         = d_reg;
        l_next         = l_reg;
        cand_next      = cand_reg;
        thr_up_next    = thr_up_reg;
        thr_dn_next    = thr_dn_reg;
        lvl_next       = lvl_reg;
        int_next       = int_reg;

        // A waiting result leaves on its transfer.
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    x_next     = x_clamped;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                case (kind_reg)
                    KIND_BOOL:
                    begin
                        flag_next   = act;
                        primed_next = 1'b1;
                        lvl_next    = act ? ONE_LVL : '0;
                        int_next    = INT_W'(act);
                        state_next  = ST_FIN;
                    end
                    KIND_DISC:
                    begin
                        if (d_pos)
                        begin
                            d_next     = d_cfg[D_W-1:0];
                            l_next     = L_W'(d_cfg[D_W-1:0] * SPAN_SCALE);
                            state_next = ST_STEP;
                        end
                        else
                        begin
                            held_next   = rmin_reg;
                            primed_next = 1'b1;
                            lvl_next    = '0;
                            int_next    = rmin_reg;
                            state_next  = ST_FIN;
                        end
                    end
                    default:
                    begin
                        // Continuous and the unused code pass the sample through.
                        lvl_next   = x_reg;
                        int_next   = '0;
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_STEP:
            begin
                cand_next   = cand_val;
                thr_up_next = (L_W+1)'(bl_up) + (L_W+1)'(ml);
                thr_dn_next = $signed({2'b00, bl_dn}) - $signed((L_W+2)'(ml));
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                if (!primed_reg)
                begin
                    held_next = cand_reg;
                end
                else if ((cand_reg > held_reg) && go_up)
                begin
                    held_next = cand_reg;
                end
                else if ((cand_reg < held_reg) && go_dn)
                begin
                    held_next = cand_reg;
                end
                primed_next = 1'b1;
                state_next  = ST_RNM;
            end
            ST_RNM:
            begin
                int_next = held_reg;
                if (n_le0)
                begin
                    lvl_next   = '0;
                    state_next = ST_FIN;
                end
                else if (n_ge_d)
                begin
                    lvl_next   = ONE_LVL;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    lvl_next   = div_quot;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = lvl_reg;
                    out_int_next   = int_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state, held state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            flag_reg      <= 1'b0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_level_reg <= '0;
            out_int_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            flag_reg      <= flag_next;
            primed_reg    <= primed_next;
            out_valid_reg <= out_valid_next;
            out_level_reg <= out_level_next;
            out_int_reg   <= out_int_next;
        end
    end

    // Per-item working registers.
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        d_reg      <= d_next;
        l_reg      <= l_next;
        cand_reg   <= cand_next;
        thr_up_reg <= thr_up_next;
        thr_dn_reg <= thr_dn_next;
        lvl_reg    <= lvl_next;
        int_reg    <= int_next;
    end

    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign stable_level = out_level_reg;
    assign held_integer = out_int_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready |-> !div_stat.busy)
        else $error("divider busy while the sequencer is idle");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (stable_level <= ONE_LVL))
        else $error("stable level above 1.0");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (div_stat.busy && (state_reg == ST_DIV)))
        else $error("divider start not followed by a division");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("second sample taken while one is in work");

endmodule
